/* sv/power_button_press_qualifier_core_assert.svh */
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef POWER_BUTTON_PRESS_QUALIFIER_CORE_ASSERT_SVH
`define POWER_BUTTON_PRESS_QUALIFIER_CORE_ASSERT_SVH

// property checked on the rising edge, muted while reset is high
`define PBQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("power button qualifier check failed");

// property checked on the rising edge in and out of reset
`define PBQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("power button qualifier check failed");

`endif

/* sv/pbq_pkg.sv */
// shared types, register map and helpers for the power button qualifier
// no dependencies
package pbq_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 16;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_PULSE_MODE    = 3'd0;
  localparam logic [2:0] REG_ALLOW_FORCE   = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE      = 3'd2;
  localparam logic [2:0] REG_POWERDOWN     = 3'd3;
  localparam logic [2:0] REG_FORCEON       = 3'd4;
  localparam logic [2:0] REG_RELEASE       = 3'd5;

  // register reset values
  localparam logic             RST_PULSE_MODE  = 1'b1;
  localparam logic             RST_ALLOW_FORCE = 1'b0;
  localparam logic [CNT_W-1:0] RST_DEBOUNCE    = 16'd100;
  localparam logic [CNT_W-1:0] RST_POWERDOWN   = 16'd2000;
  localparam logic [CNT_W-1:0] RST_FORCEON     = 16'd5000;
  localparam logic [CNT_W-1:0] RST_RELEASE     = 16'd500;

  typedef struct packed {
    logic             pulse_toggle_mode;
    logic             allow_force_on;
    logic [CNT_W-1:0] debounce_ms;
    logic [CNT_W-1:0] powerdown_hold_ms;
    logic [CNT_W-1:0] forceon_hold_ms;
    logic [CNT_W-1:0] release_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic button_pressed;
    logic powerdown_request;
    logic force_on_pulse;
    logic long_startup_press;
    logic held_at_startup;
  } res_t;

  // saturating increment of a millisecond counter
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

/* sv/pbq_cfg_regs.sv */
// apb register file holding the qualifier thresholds and mode bits
// depends on pbq_pkg
module pbq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pbq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pbq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output pbq_pkg::cfg_t                  cfg
);
  import pbq_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_toggle_mode  <= RST_PULSE_MODE;
      cfg.allow_force_on     <= RST_ALLOW_FORCE;
      cfg.debounce_ms        <= RST_DEBOUNCE;
      cfg.powerdown_hold_ms  <= RST_POWERDOWN;
      cfg.forceon_hold_ms    <= RST_FORCEON;
      cfg.release_timeout_ms <= RST_RELEASE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PULSE_MODE:  cfg.pulse_toggle_mode  <= pwdata[0];
        REG_ALLOW_FORCE: cfg.allow_force_on     <= pwdata[0];
        REG_DEBOUNCE:    cfg.debounce_ms        <= pwdata[CNT_W-1:0];
        REG_POWERDOWN:   cfg.powerdown_hold_ms  <= pwdata[CNT_W-1:0];
        REG_FORCEON:     cfg.forceon_hold_ms    <= pwdata[CNT_W-1:0];
        REG_RELEASE:     cfg.release_timeout_ms <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_PULSE_MODE:  prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.pulse_toggle_mode};
      REG_ALLOW_FORCE: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.allow_force_on};
      REG_DEBOUNCE:    prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg.debounce_ms};
      REG_POWERDOWN:   prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg.powerdown_hold_ms};
      REG_FORCEON:     prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg.forceon_hold_ms};
      REG_RELEASE:     prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, cfg.release_timeout_ms};
      default:         prdata = '0;
    endcase
  end

endmodule

/* sv/pbq_tracker.sv */
// per-tick button state: edges, held and quiet counters, qualified flags
// depends on pbq_pkg
module pbq_tracker (
  input  logic          clk,
  input  logic          rst,
  input  pbq_pkg::cfg_t cfg,
  input  logic          advance,
  input  logic          level,
  output pbq_pkg::res_t res
);
  import pbq_pkg::*;

  logic             started, last_level, first_press, actuated, pressed;
  logic             powerdown_desired, forceon_desired, forceon_given, long_press_seen;
  logic [CNT_W-1:0] held_count, quiet_count;

  logic             first_press_next, actuated_next, pressed_next;
  logic             powerdown_desired_next, forceon_desired_next, forceon_given_next;
  logic             long_press_seen_next;
  logic [CNT_W-1:0] held_count_next, quiet_count_next;

  logic             prev_level, fp_base, rising, falling, give_force;
  logic [CNT_W-1:0] held_base, quiet_inc;

  // next state for one tick
  always_comb begin
    // first tick latches the start-up level
    prev_level = started ? last_level : level;
    fp_base    = started ? first_press : level;
    rising     = !prev_level && level;
    falling    = prev_level && !level;

    first_press_next = falling ? 1'b0 : fp_base;
    actuated_next    = falling ? 1'b1 : (rising ? 1'b0 : actuated);
    held_base        = rising ? '0 : held_count;

    pressed_next           = pressed;
    powerdown_desired_next = powerdown_desired;
    forceon_desired_next   = forceon_desired;
    long_press_seen_next   = long_press_seen;
    quiet_inc              = sat_inc(quiet_count);
    quiet_count_next       = quiet_count;

    if (level) begin
      if (held_base > cfg.debounce_ms && !first_press_next)
        pressed_next = 1'b1;
      if (held_base >= cfg.powerdown_hold_ms && !first_press_next && cfg.pulse_toggle_mode)
        powerdown_desired_next = 1'b1;
      if (held_base >= cfg.forceon_hold_ms && first_press_next && cfg.pulse_toggle_mode) begin
        if (cfg.allow_force_on)
          forceon_desired_next = 1'b1;
        long_press_seen_next = 1'b1;
      end
      quiet_count_next = '0;
    end else begin
      // release timeout fires and restarts the quiet counter
      if (quiet_inc >= cfg.release_timeout_ms) begin
        quiet_count_next = '0;
        if (actuated_next)
          pressed_next = 1'b0;
      end else begin
        quiet_count_next = quiet_inc;
      end
    end
    held_count_next = sat_inc(held_base);

    // force-on is handed out once
    give_force         = forceon_desired_next && !forceon_given;
    forceon_given_next = forceon_given || give_force;
    if (give_force)
      forceon_desired_next = 1'b0;

    res.button_pressed     = pressed_next;
    res.powerdown_request  = cfg.pulse_toggle_mode ? powerdown_desired_next : !pressed_next;
    res.force_on_pulse     = give_force;
    res.long_startup_press = long_press_seen_next;
    res.held_at_startup    = first_press_next;
  end

  // state update on each tick that moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      started           <= 1'b0;
      last_level        <= 1'b0;
      first_press       <= 1'b0;
      actuated          <= 1'b0;
      pressed           <= 1'b1;
      powerdown_desired <= 1'b0;
      forceon_desired   <= 1'b0;
      forceon_given     <= 1'b0;
      long_press_seen   <= 1'b0;
      held_count        <= '0;
      quiet_count       <= '0;
    end else if (advance) begin
      started           <= 1'b1;
      last_level        <= level;
      first_press       <= first_press_next;
      actuated          <= actuated_next;
      pressed           <= pressed_next;
      powerdown_desired <= powerdown_desired_next;
      forceon_desired   <= forceon_desired_next;
      forceon_given     <= forceon_given_next;
      long_press_seen   <= long_press_seen_next;
      held_count        <= held_count_next;
      quiet_count       <= quiet_count_next;
    end
  end

endmodule

/* sv/power_button_press_qualifier_core.sv */
// Power button press qualifier. Each input beat is one millisecond sample of
// the button level; each yields exactly one result beat with the qualified
// pressed state, power-down request, one-shot force-on pulse and start-up
// flags. A beat is taken into an input register and moves to a result register
// once that register is empty or being drained, and one beat is taken every
// cycle while the output is drained; the single state update between those
// registers sets that rate. Thresholds and modes sit in an APB register file;
// the user must write them only while no beat is in flight, as the block
// does not enforce this.
module power_button_press_qualifier_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pbq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pbq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           button_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           button_pressed,
  output logic                           powerdown_request,
  output logic                           force_on_pulse,
  output logic                           long_startup_press,
  output logic                           held_at_startup
);
  import pbq_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic in_full, in_level, advance;

  pbq_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // beat moves from input register to result register
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  pbq_tracker u_trk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .level   (in_level),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst)
      in_full <= 1'b0;
    else if (in_ready)
      in_full <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      in_level <= button_level;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (advance)
      out_valid <= 1'b1;
    else if (out_ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance)
      out_res <= res;
  end

  assign button_pressed     = out_res.button_pressed;
  assign powerdown_request  = out_res.powerdown_request;
  assign force_on_pulse     = out_res.force_on_pulse;
  assign long_startup_press = out_res.long_startup_press;
  assign held_at_startup    = out_res.held_at_startup;

endmodule

/* sv/pbq_checker.sv */
// port-level checks for the power button qualifier, bound to the top level
// depends on pbq_pkg and power_button_press_qualifier_core_assert.svh
`include "power_button_press_qualifier_core_assert.svh"

module pbq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic                           pready,
  input logic [pbq_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [pbq_pkg::CFG_DATA_W-1:0] pwdata,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           button_pressed,
  input logic                           powerdown_request,
  input logic                           force_on_pulse,
  input logic                           long_startup_press,
  input logic                           held_at_startup
);
  import pbq_pkg::*;

  logic       mode_shadow;
  logic       force_seen;
  logic       out_fire;
  logic       out_stall;
  logic       level_req_ok;
  logic [4:0] out_bits;

  assign out_fire     = out_valid && out_ready;
  assign out_stall    = out_valid && !out_ready;
  assign level_req_ok = (powerdown_request == !button_pressed);
  assign out_bits     = {button_pressed, powerdown_request, force_on_pulse,
                         long_startup_press, held_at_startup};

  // shadow of the mode bit and of a delivered force-on beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_shadow <= RST_PULSE_MODE;
      force_seen  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_PULSE_MODE)
        mode_shadow <= pwdata[0];
      if (out_fire && force_on_pulse)
        force_seen <= 1'b1;
    end
  end

  `PBQ_ASSERT(a_force_once, clk, rst, (out_fire && force_on_pulse) |-> !force_seen)
  `PBQ_ASSERT(a_force_implies_long, clk, rst, (out_valid && force_on_pulse) |-> long_startup_press)
  `PBQ_ASSERT(a_level_mode_request, clk, rst, (out_valid && !mode_shadow) |-> level_req_ok)
  `PBQ_ASSERT(a_out_hold, clk, rst, out_stall |=> (out_valid && $stable(out_bits)))

endmodule

bind power_button_press_qualifier_core pbq_checker u_pbq_checker (
  .clk                (clk),
  .rst                (rst),
  .psel               (psel),
  .penable            (penable),
  .pwrite             (pwrite),
  .pready             (pready),
  .paddr              (paddr),
  .pwdata             (pwdata),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .button_pressed     (button_pressed),
  .powerdown_request  (powerdown_request),
  .force_on_pulse     (force_on_pulse),
  .long_startup_press (long_startup_press),
  .held_at_startup    (held_at_startup)
);
